@@ sv/traffic_ca_vehicle_step_unit_assert.svh @@
// Assertion macros for the traffic lane step unit.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TRAFFIC_CA_VEHICLE_STEP_UNIT_ASSERT_SVH
`define TRAFFIC_CA_VEHICLE_STEP_UNIT_ASSERT_SVH

// property holds at every edge out of reset
`define TCVS_ASSERT_HOLD(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent this edge implies consequent next edge
`define TCVS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tcvs_pkg.sv @@
// Shared types, constants and helpers for the traffic lane step unit.
// No dependencies.
package tcvs_pkg;

  localparam int POS_W          = 6;
  localparam int VEL_W          = 4;
  localparam int LEN_W          = 7;
  localparam int DRAW_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int LANE_CELLS_DEF = 64;
  localparam int DRAW_BITS_DEF  = 16;

  localparam logic [VEL_W-1:0] BUMP_SPEED      = 4'd1;
  localparam logic [LEN_W-1:0] LANE_LEN_RESET  = 7'd64;
  localparam logic [LEN_W-1:0] LANE_LEN_MIN    = 7'd2;
  localparam logic [VEL_W-1:0] MAX_VEL_RESET   = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LANE_LENGTH     = 3'd0,
    REG_MAX_VELOCITY    = 3'd1,
    REG_BRAKE_THRESHOLD = 3'd2,
    REG_ENTRY_THRESHOLD = 3'd3,
    REG_EXIT_THRESHOLD  = 3'd4,
    REG_BUMP_MAP        = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_VEHICLE = 1'b0,
    OP_ENTRY   = 1'b1
  } op_e;

  typedef struct packed {
    logic [LEN_W-1:0]  lane_len;   // already clamped to the usable range
    logic [VEL_W-1:0]  max_vel;
    logic [DRAW_W-1:0] brake_th;   // thresholds already masked to the draw width
    logic [DRAW_W-1:0] entry_th;
    logic [DRAW_W-1:0] exit_th;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  vehicle_position;
    logic [VEL_W-1:0]  vehicle_velocity;
    logic [POS_W-1:0]  ahead_position;
    logic              is_leading;
    logic              first_cell_free;
    logic [DRAW_W-1:0] brake_draw;
    logic [DRAW_W-1:0] exit_draw;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] next_cell;
    logic [VEL_W-1:0] next_speed;
    logic             left_lane;
    logic             entered;
    logic [LEN_W-1:0] vehicles_in_lane;
  } result_t;

  // low-bits mask for draws and thresholds
  function automatic logic [DRAW_W-1:0] draw_mask(input int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    if (bits >= DRAW_W) return '1;
    return m[DRAW_W-1:0];
  endfunction

endpackage

@@ sv/tcvs_bump.sv @@
// Priority encoder: nearest speed bump at or ahead of a cell, inside the lane.
// Depends on tcvs_pkg.
module tcvs_bump import tcvs_pkg::*; #(
  parameter int LANE_CELLS = LANE_CELLS_DEF
) (
  input  logic [LANE_CELLS-1:0] bump_i,
  input  logic [LEN_W-1:0]      len_i,
  input  logic [POS_W-1:0]      pos_i,
  output logic                  found_o,
  output logic [POS_W-1:0]      dist_o
);

  localparam int IDX_W = (LANE_CELLS > 1) ? $clog2(LANE_CELLS) : 1;

  logic [IDX_W-1:0] hit_idx;

  // scan from the far end so the lowest qualifying cell wins
  always_comb begin
    found_o = 1'b0;
    hit_idx = '0;
    for (int k = LANE_CELLS - 1; k >= 0; k--) begin
      if (bump_i[k] && (LEN_W'(k) < len_i) && (POS_W'(k) >= pos_i)) begin
        found_o = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign dist_o = POS_W'(hit_idx) - pos_i;

endmodule

@@ sv/tcvs_cfg.sv @@
// Configuration register file with the write channel.
// Depends on tcvs_pkg.
module tcvs_cfg import tcvs_pkg::*; #(
  parameter int LANE_CELLS = LANE_CELLS_DEF,
  parameter int DRAW_BITS  = DRAW_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output logic [LANE_CELLS-1:0] bump_o
);

  localparam logic [DRAW_W-1:0] DrawMask = draw_mask(DRAW_BITS);
  localparam logic [LEN_W-1:0]  LenMax   = LEN_W'(LANE_CELLS);

  logic [LEN_W-1:0]      lane_len_q;
  logic [VEL_W-1:0]      max_vel_q;
  logic [DRAW_W-1:0]     brake_th_q, entry_th_q, exit_th_q;
  logic [LANE_CELLS-1:0] bump_q;
  logic                  wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_len_q <= LANE_LEN_RESET;
      max_vel_q  <= MAX_VEL_RESET;
      brake_th_q <= '0;
      entry_th_q <= '0;
      exit_th_q  <= '0;
      bump_q     <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        REG_LANE_LENGTH:     lane_len_q <= cfg_data_i[LEN_W-1:0];
        REG_MAX_VELOCITY:    max_vel_q  <= cfg_data_i[VEL_W-1:0];
        REG_BRAKE_THRESHOLD: brake_th_q <= cfg_data_i[DRAW_W-1:0];
        REG_ENTRY_THRESHOLD: entry_th_q <= cfg_data_i[DRAW_W-1:0];
        REG_EXIT_THRESHOLD:  exit_th_q  <= cfg_data_i[DRAW_W-1:0];
        REG_BUMP_MAP:        bump_q     <= cfg_data_i[LANE_CELLS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lane_len_q < LANE_LEN_MIN) begin
      cfg_o.lane_len = LANE_LEN_MIN;
    end else if (lane_len_q > LenMax) begin
      cfg_o.lane_len = LenMax;
    end else begin
      cfg_o.lane_len = lane_len_q;
    end
    cfg_o.max_vel  = max_vel_q;
    cfg_o.brake_th = brake_th_q & DrawMask;
    cfg_o.entry_th = entry_th_q & DrawMask;
    cfg_o.exit_th  = exit_th_q & DrawMask;
  end

  assign bump_o = bump_q;

endmodule

@@ sv/tcvs_rule.sv @@
// Single-pass lane rule: entry attempt or one vehicle update, plus next count.
// Depends on tcvs_pkg and tcvs_bump.
module tcvs_rule import tcvs_pkg::*; #(
  parameter int LANE_CELLS = LANE_CELLS_DEF,
  parameter int DRAW_BITS  = DRAW_BITS_DEF
) (
  input  item_t                 item_i,
  input  cfg_t                  cfg_i,
  input  logic [LANE_CELLS-1:0] bump_i,
  input  logic [LEN_W-1:0]      count_i,
  output result_t               res_o,
  output logic [LEN_W-1:0]      count_o
);

  localparam logic [DRAW_W-1:0] DrawMask = draw_mask(DRAW_BITS);

  logic              bump_found;
  logic [POS_W-1:0]  bump_dist;
  logic [DRAW_W-1:0] bdraw, xdraw;
  logic [POS_W-1:0]  headway;
  logic [VEL_W:0]    vel_inc;
  logic [VEL_W-1:0]  v_acc, v_gap, v_bump, v_fin;
  logic [LEN_W-1:0]  dest;
  logic              leaves;

  tcvs_bump #(
    .LANE_CELLS(LANE_CELLS)
  ) u_bump (
    .bump_i (bump_i),
    .len_i  (cfg_i.lane_len),
    .pos_i  (item_i.vehicle_position),
    .found_o(bump_found),
    .dist_o (bump_dist)
  );

  always_comb begin
    bdraw = item_i.brake_draw & DrawMask;
    xdraw = item_i.exit_draw & DrawMask;

    if (item_i.is_leading) begin
      headway = POS_W'(cfg_i.max_vel);
    end else if (item_i.ahead_position > item_i.vehicle_position) begin
      headway = item_i.ahead_position - item_i.vehicle_position - POS_W'(1);
    end else begin
      headway = '0;
    end

    vel_inc = {1'b0, item_i.vehicle_velocity} + (VEL_W+1)'(1);
    v_acc   = (vel_inc < {1'b0, cfg_i.max_vel}) ? vel_inc[VEL_W-1:0] : cfg_i.max_vel;
    v_gap   = (POS_W'(v_acc) < headway) ? v_acc : headway[VEL_W-1:0];

    // bump on the current cell forces bump speed, capped by the headway, even above the gap speed
    v_bump = v_gap;
    if (bump_found) begin
      if (bump_dist == '0) begin
        v_bump = (headway < POS_W'(BUMP_SPEED)) ? headway[VEL_W-1:0] : BUMP_SPEED;
      end else if (bump_dist < POS_W'(v_gap)) begin
        v_bump = (bump_dist < headway) ? bump_dist[VEL_W-1:0] : headway[VEL_W-1:0];
      end
    end

    v_fin = v_bump;
    if ((bdraw < cfg_i.brake_th) && (v_bump != '0)) begin
      v_fin = v_bump - VEL_W'(1);
    end

    dest   = LEN_W'(item_i.vehicle_position) + LEN_W'(v_fin);
    leaves = item_i.is_leading && (cfg_i.exit_th != '0) && (xdraw < cfg_i.exit_th);

    res_o   = '0;
    count_o = count_i;
    if (item_i.op == OP_ENTRY) begin
      if ((count_i < cfg_i.lane_len) && item_i.first_cell_free &&
          (cfg_i.entry_th != '0) && (bdraw < cfg_i.entry_th)) begin
        res_o.entered = 1'b1;
        count_o       = count_i + LEN_W'(1);
      end
    end else begin
      res_o.next_speed = v_fin;
      if (dest >= cfg_i.lane_len) begin
        if (leaves) begin
          res_o.left_lane = 1'b1;
          if (count_i != '0) begin
            count_o = count_i - LEN_W'(1);
          end
        end else begin
          // stuck at the last cell
          res_o.next_cell = POS_W'(cfg_i.lane_len - LEN_W'(1));
        end
      end else begin
        res_o.next_cell = dest[POS_W-1:0];
      end
    end
    res_o.vehicles_in_lane = count_o;
  end

endmodule

@@ sv/traffic_ca_vehicle_step_unit.sv @@
// Top level of the open-boundary traffic lane step unit.
// Depends on tcvs_pkg, tcvs_cfg, tcvs_rule and traffic_ca_vehicle_step_unit_assert.svh.

// Each input word is one lane rule evaluation: an entry attempt at cell 0 or the update
// of one vehicle (accelerate, keep headway, slow for bumps, random brake, move, leave).
// One word is accepted every clock cycle while results are taken; a result is presented
// from the result register after its word has passed the input register, with the whole
// rule evaluated in the single combinational pass between the input and the result
// register. The vehicle count is updated as a word leaves the input register,
// so consecutive words see the count left by the word before. The result register lets
// a new word in while a finished result still waits. Write configuration only while the
// unit is empty.
module traffic_ca_vehicle_step_unit import tcvs_pkg::*; #(
  parameter int LANE_CELLS = LANE_CELLS_DEF,
  parameter int DRAW_BITS  = DRAW_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [POS_W-1:0]      vehicle_position_i,
  input  logic [VEL_W-1:0]      vehicle_velocity_i,
  input  logic [POS_W-1:0]      ahead_position_i,
  input  logic                  is_leading_i,
  input  logic                  first_cell_free_i,
  input  logic [DRAW_W-1:0]     brake_draw_i,
  input  logic [DRAW_W-1:0]     exit_draw_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      next_cell_o,
  output logic [VEL_W-1:0]      next_speed_o,
  output logic                  left_lane_o,
  output logic                  entered_o,
  output logic [LEN_W-1:0]      vehicles_in_lane_o
);

  `include "traffic_ca_vehicle_step_unit_assert.svh"

  cfg_t                  cfg;
  logic [LANE_CELLS-1:0] bump;

  logic             in_valid_q;
  item_t            item_q;
  logic             out_valid_q;
  result_t          res_q, res_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic             advance, in_take;

  tcvs_cfg #(
    .LANE_CELLS(LANE_CELLS),
    .DRAW_BITS (DRAW_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .bump_o     (bump)
  );

  tcvs_rule #(
    .LANE_CELLS(LANE_CELLS),
    .DRAW_BITS (DRAW_BITS)
  ) u_rule (
    .item_i (item_q),
    .cfg_i  (cfg),
    .bump_i (bump),
    .count_i(count_q),
    .res_o  (res_d),
    .count_o(count_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op               <= op_e'(op_i);
      item_q.vehicle_position <= vehicle_position_i;
      item_q.vehicle_velocity <= vehicle_velocity_i;
      item_q.ahead_position   <= ahead_position_i;
      item_q.is_leading       <= is_leading_i;
      item_q.first_cell_free  <= first_cell_free_i;
      item_q.brake_draw       <= brake_draw_i;
      item_q.exit_draw        <= exit_draw_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign next_cell_o        = res_q.next_cell;
  assign next_speed_o       = res_q.next_speed;
  assign left_lane_o        = res_q.left_lane;
  assign entered_o          = res_q.entered;
  assign vehicles_in_lane_o = res_q.vehicles_in_lane;

  `TCVS_ASSERT_HOLD(a_count_bound, count_q <= LEN_W'(LANE_CELLS), "vehicle count overflow")
  `TCVS_ASSERT_HOLD(a_one_event, !(out_valid_o && entered_o && left_lane_o), "entry with exit")
  `TCVS_ASSERT_NEXT(a_count_stable, !advance, $stable(count_q), "count moved without a word")
  `TCVS_ASSERT_NEXT(a_no_drop, in_valid_q && out_valid_q && !out_ready_i, in_valid_q, "stalled word lost")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for traffic_ca_vehicle_step_unit: directed lane rule cases,
// then randomised traffic ticks over several register settings.
// Depends on tcvs_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
  import tcvs_pkg::*;

  localparam int LANE_CELLS = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  item_t                 in_word = '0;
  logic                  out_ready = 1'b0;

  logic             cfg_ready_o;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [POS_W-1:0] next_cell_o;
  logic [VEL_W-1:0] next_speed_o;
  logic             left_lane_o;
  logic             entered_o;
  logic [LEN_W-1:0] vehicles_in_lane_o;

  // predictor copy of the registers and the vehicle count
  logic [LEN_W-1:0]  lane_len_cfg = LANE_LEN_RESET;
  logic [VEL_W-1:0]  max_vel_cfg = MAX_VEL_RESET;
  logic [DRAW_W-1:0] brake_th_cfg = '0;
  logic [DRAW_W-1:0] entry_th_cfg = '0;
  logic [DRAW_W-1:0] exit_th_cfg = '0;
  logic [63:0]       bump_cfg = '0;
  logic [LEN_W-1:0]  count_model = '0;

  result_t pending_results[$];
  result_t due;
  int      mismatches = 0;
  bit      full_rate = 1'b0;
  int      ready_hold = 0;
  int      stall_draw;

  // software lane used to build well-formed ticks, leader first
  int lane_pos[$];
  int lane_vel[$];

  traffic_ca_vehicle_step_unit #(
    .LANE_CELLS (LANE_CELLS),
    .DRAW_BITS  (DRAW_BITS_DEF)
  ) uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .op_i               (in_word.op),
    .vehicle_position_i (in_word.vehicle_position),
    .vehicle_velocity_i (in_word.vehicle_velocity),
    .ahead_position_i   (in_word.ahead_position),
    .is_leading_i       (in_word.is_leading),
    .first_cell_free_i  (in_word.first_cell_free),
    .brake_draw_i       (in_word.brake_draw),
    .exit_draw_i        (in_word.exit_draw),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .next_cell_o        (next_cell_o),
    .next_speed_o       (next_speed_o),
    .left_lane_o        (left_lane_o),
    .entered_o          (entered_o),
    .vehicles_in_lane_o (vehicles_in_lane_o)
  );

  always #5 clk = ~clk;

  // One lane rule evaluation; updates the predicted vehicle count.
  function automatic result_t lane_rule(input item_t w);
    result_t r;
    int len, pos, headway, v, bump_gap, dest, k;
    r = '0;
    len = lane_len_cfg;
    if (len < 2) len = 2;
    if (len > LANE_CELLS) len = LANE_CELLS;
    pos = w.vehicle_position;
    if (w.op == OP_ENTRY) begin
      if (count_model < len && w.first_cell_free && entry_th_cfg != 0 &&
          w.brake_draw < entry_th_cfg) begin
        r.entered = 1'b1;
        count_model = count_model + 1'b1;
      end
    end else begin
      if (w.is_leading) headway = max_vel_cfg;
      else if (w.ahead_position > w.vehicle_position) headway = w.ahead_position - pos - 1;
      else headway = 0;
      v = w.vehicle_velocity + 1;
      if (v > max_vel_cfg) v = max_vel_cfg;
      if (v > headway) v = headway;
      // nearest bump at or ahead, bits outside the lane ignored
      bump_gap = len;
      for (k = len - 1; k >= pos; k--)
        if (bump_cfg[k]) bump_gap = k - pos;
      if (bump_gap < len) begin
        if (bump_gap == 0) v = (headway < BUMP_SPEED) ? headway : BUMP_SPEED;
        else if (bump_gap < v) v = (headway < bump_gap) ? headway : bump_gap;
      end
      if (w.brake_draw < brake_th_cfg && v > 0) v = v - 1;
      dest = pos + v;
      r.next_speed = VEL_W'(v);
      if (dest >= len) begin
        if (w.is_leading && exit_th_cfg != 0 && w.exit_draw < exit_th_cfg) begin
          r.left_lane = 1'b1;
          r.next_cell = '0;
          if (count_model > 0) count_model = count_model - 1'b1;
        end else begin
          r.next_cell = POS_W'(len - 1);
        end
      end else begin
        r.next_cell = POS_W'(dest);
      end
    end
    r.vehicles_in_lane = count_model;
    return r;
  endfunction

  function automatic item_t make_entry(input bit free0, input int draw);
    item_t w;
    w.op = OP_ENTRY;
    w.vehicle_position = POS_W'($urandom_range(0, 63));
    w.vehicle_velocity = VEL_W'($urandom_range(0, 15));
    w.ahead_position = POS_W'($urandom_range(0, 63));
    w.is_leading = 1'($urandom_range(0, 1));
    w.first_cell_free = free0;
    w.brake_draw = DRAW_W'(draw);
    w.exit_draw = DRAW_W'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic item_t make_vehicle(input int pos, input int vel, input int ahead,
                                         input bit lead, input int bdraw, input int xdraw);
    item_t w;
    w.op = OP_VEHICLE;
    w.vehicle_position = POS_W'(pos);
    w.vehicle_velocity = VEL_W'(vel);
    w.ahead_position = POS_W'(ahead);
    w.is_leading = lead;
    w.first_cell_free = 1'($urandom_range(0, 1));
    w.brake_draw = DRAW_W'(bdraw);
    w.exit_draw = DRAW_W'(xdraw);
    return w;
  endfunction

  function automatic item_t random_word();
    item_t w;
    w = make_vehicle($urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
    w.op = op_e'($urandom_range(0, 1));
    return w;
  endfunction

  // Sends a word after a random gap, none at full rate; gives the predicted result.
  task automatic send_word(input item_t w, output result_t r);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    r = lane_rule(w);
    pending_results = {pending_results, r};
  endtask

  task automatic push_word(input item_t w);
    result_t r;
    send_word(w, r);
  endtask

  // Register write, only once the unit has drained.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_LANE_LENGTH:     lane_len_cfg = value[LEN_W-1:0];
      REG_MAX_VELOCITY:    max_vel_cfg = value[VEL_W-1:0];
      REG_BRAKE_THRESHOLD: brake_th_cfg = value[DRAW_W-1:0];
      REG_ENTRY_THRESHOLD: entry_th_cfg = value[DRAW_W-1:0];
      REG_EXIT_THRESHOLD:  exit_th_cfg = value[DRAW_W-1:0];
      REG_BUMP_MAP:        bump_cfg = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: a random stall after each result taken, none in full-rate mode
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_ready && out_valid_o) begin
      stall_draw = full_rate ? 0 : $urandom_range(0, 4);
      out_ready <= (stall_draw == 0);
      ready_hold <= stall_draw;
    end else if (!out_ready) begin
      if (ready_hold > 1) begin
        ready_hold <= ready_hold - 1;
      end else begin
        ready_hold <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word expected none got pos %0d vel %0d count %0d", $time,
                 next_cell_o, next_speed_o, vehicles_in_lane_o);
        mismatches++;
      end else begin
        due = pending_results.pop_front();
        check_field("next_cell", 8'(due.next_cell), 8'(next_cell_o));
        check_field("next_speed", 8'(due.next_speed), 8'(next_speed_o));
        check_field("left_lane", 8'(due.left_lane), 8'(left_lane_o));
        check_field("entered", 8'(due.entered), 8'(entered_o));
        check_field("vehicles_in_lane", 8'(due.vehicles_in_lane), 8'(vehicles_in_lane_o));
      end
    end
  end

  task automatic test_reset_state();
    push_word(make_entry(1'b1, 0));                        // entry disabled at reset
    push_word(make_vehicle(63, 15, 0, 1'b1, 0, 0));        // leader held at last cell
  endtask

  task automatic test_entry();
    write_reg(REG_ENTRY_THRESHOLD, 64'hFFFF);
    write_reg(REG_LANE_LENGTH, 64'd0);                     // clamps to two cells
    push_word(make_entry(1'b1, 16'hFFFE));
    push_word(make_entry(1'b1, 16'hFFFF));                 // draw equal to threshold
    push_word(make_entry(1'b0, 0));                        // cell 0 taken
    push_word(make_entry(1'b1, 0));
    push_word(make_entry(1'b1, 0));                        // lane full
    write_reg(REG_LANE_LENGTH, 64'd127);
    write_reg(REG_ENTRY_THRESHOLD, 64'd1);
    push_word(make_entry(1'b1, 0));
  endtask

  task automatic test_vehicle_rules();
    write_reg(REG_MAX_VELOCITY, 64'd15);
    push_word(make_vehicle(10, 3, 10, 1'b0, 16'hFFFF, 0));  // ahead at same cell
    push_word(make_vehicle(10, 15, 5, 1'b0, 16'hFFFF, 0));  // ahead behind
    push_word(make_vehicle(10, 2, 20, 1'b0, 16'hFFFF, 0));
    push_word(make_vehicle(0, 15, 0, 1'b1, 16'hFFFF, 0));
    push_word(make_vehicle(60, 14, 63, 1'b0, 16'hFFFF, 0));
    write_reg(REG_LANE_LENGTH, 64'd20);
    push_word(make_vehicle(18, 5, 40, 1'b0, 16'hFFFF, 0));  // follower saturates
    push_word(make_vehicle(30, 0, 63, 1'b0, 16'hFFFF, 0));  // starts beyond the lane
    write_reg(REG_BRAKE_THRESHOLD, 64'hFFFF);
    push_word(make_vehicle(0, 3, 0, 1'b1, 0, 0));
    push_word(make_vehicle(0, 3, 0, 1'b1, 16'hFFFF, 0));
    push_word(make_vehicle(7, 2, 8, 1'b0, 0, 0));            // brake at standstill
  endtask

  task automatic test_bumps();
    write_reg(REG_BRAKE_THRESHOLD, 64'd0);
    write_reg(REG_LANE_LENGTH, 64'd64);
    write_reg(REG_BUMP_MAP, (64'd1 << 5) | (64'd1 << 63));
    push_word(make_vehicle(5, 4, 0, 1'b1, 16'hFFFF, 0));    // on the bump
    push_word(make_vehicle(2, 9, 0, 1'b1, 16'hFFFF, 0));    // bump nearer than speed
    push_word(make_vehicle(5, 4, 6, 1'b0, 16'hFFFF, 0));    // on bump, no headway
    write_reg(REG_LANE_LENGTH, 64'd20);
    write_reg(REG_BUMP_MAP, (64'd1 << 30) | (64'd1 << 63));
    push_word(make_vehicle(15, 4, 0, 1'b1, 16'hFFFF, 0));   // bumps outside the lane
  endtask

  task automatic test_leaving();
    write_reg(REG_EXIT_THRESHOLD, 64'h8000);
    push_word(make_vehicle(18, 5, 0, 1'b1, 16'hFFFF, 16'h7FFF));
    push_word(make_vehicle(18, 5, 0, 1'b1, 16'hFFFF, 16'h8000));
    push_word(make_vehicle(18, 5, 40, 1'b0, 16'hFFFF, 0));   // follower never leaves
    push_word(make_vehicle(16, 9, 0, 1'b1, 16'hFFFF, 0));
    push_word(make_vehicle(16, 9, 0, 1'b1, 16'hFFFF, 0));
    push_word(make_vehicle(16, 9, 0, 1'b1, 16'hFFFF, 0));    // exit with count at zero
  endtask

  // Ticks: entry attempt, every vehicle leader first on old cells; random words too.
  task automatic run_ticks(input int n_items);
    int sent, i, ahead;
    int next_pos[$];
    int next_vel[$];
    bit free0, came_in;
    result_t r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        send_word(random_word(), r);
        sent++;
      end
      free0 = (lane_pos.size() == 0 || lane_pos[$] != 0) && lane_pos.size() < LANE_CELLS;
      send_word(make_entry(free0, $urandom_range(0, 65535)), r);
      sent++;
      came_in = r.entered;
      next_pos.delete();
      next_vel.delete();
      for (i = 0; i < lane_pos.size(); i++) begin
        if (i == 0 || $urandom_range(0, 15) == 0) ahead = $urandom_range(0, 63);
        else ahead = lane_pos[i-1];
        send_word(make_vehicle(lane_pos[i], lane_vel[i], ahead, i == 0,
                               $urandom_range(0, 65535), $urandom_range(0, 65535)), r);
        sent++;
        if (!r.left_lane) begin
          next_pos = {next_pos, int'(r.next_cell)};
          next_vel = {next_vel, int'(r.next_speed)};
        end
      end
      lane_pos = next_pos;
      lane_vel = next_vel;
      if (came_in) begin
        lane_pos = {lane_pos, 0};
        lane_vel = {lane_vel, 0};
      end
    end
  endtask

  task automatic set_regs(input int len, input int vmax, input int brake, input int entry,
                          input int leave, input logic [63:0] bumps);
    write_reg(REG_LANE_LENGTH, 64'(len));
    write_reg(REG_MAX_VELOCITY, 64'(vmax));
    write_reg(REG_BRAKE_THRESHOLD, 64'(brake));
    write_reg(REG_ENTRY_THRESHOLD, 64'(entry));
    write_reg(REG_EXIT_THRESHOLD, 64'(leave));
    write_reg(REG_BUMP_MAP, bumps);
  endtask

  task automatic test_random_traffic();
    set_regs(64, 5, 16'h4000, 16'h8000, 16'h8000,
             {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    run_ticks(280);
    set_regs(2, 15, 0, 16'hFFFF, 16'hFFFF, '1);
    run_ticks(280);
    set_regs(127, 1, 0, 16'hFFFF, 0, '0);
    run_ticks(280);
    set_regs(20, 0, $urandom_range(0, 65535), $urandom_range(0, 65535),
             $urandom_range(0, 65535), {$urandom, $urandom} & {$urandom, $urandom});
    run_ticks(280);
    set_regs($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(0, 65535), {$urandom, $urandom});
    run_ticks(280);
    // back-to-back words, no stalls on either side
    set_regs(64, 15, 16'h8000, 16'hFFFF, 16'h1000, {$urandom, $urandom} & {$urandom, $urandom});
    full_rate = 1'b1;
    run_ticks(280);
    full_rate = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_state();
    test_entry();
    test_vehicle_rules();
    test_bumps();
    test_leaving();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
